### rtl/bas_pkg.sv
// Shared types and constants for the advertising payload scanner.
package bas_pkg;

  // Longest name kept is NAME_MAX-1 bytes.
  localparam int NAME_MAX = 32;
  localparam logic [7:0] NameLimit = 8'(NAME_MAX - 1);

  // AD structure types of interest.
  localparam logic [7:0] AdUuid16Part  = 8'h02;
  localparam logic [7:0] AdUuid16Full  = 8'h03;
  localparam logic [7:0] AdNameShort   = 8'h08;
  localparam logic [7:0] AdNameFull    = 8'h09;
  localparam logic [15:0] MatchUuidRst = 16'h1826;

  // Result kinds.
  localparam logic KindName    = 1'b0;
  localparam logic KindSummary = 1'b1;

  // Result queue geometry.
  localparam int FifoDepth = 4;
  localparam int FifoAw    = $clog2(FifoDepth);
  localparam int FifoCw    = $clog2(FifoDepth + 1);

  // One result item as it sits in the queue.
  typedef struct packed {
    logic       kind;
    logic [7:0] name_byte;
    logic       uuid_found;
    logic [7:0] name_length;
    logic       result_last;
  } result_t;

  // Results caused by one accepted byte: an optional name byte, then an
  // optional summary.
  typedef struct packed {
    logic       name_vld;
    logic [7:0] name_byte;
    logic       sum_vld;
    logic       found;
    logic [7:0] name_len;
  } res_pair_t;

endpackage

### rtl/bas_parser.sv
// AD structure walker: per-byte parse state and the results each byte causes.
module bas_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        adv_byte,
  input  logic [7:0]        adv_len,
  input  logic              last,
  input  logic [15:0]       uuid_cfg,
  output bas_pkg::res_pair_t res
);

  typedef enum logic [3:0] {
    PH_LEN  = 4'b0001,
    PH_TYPE = 4'b0010,
    PH_PAY  = 4'b0100,
    PH_STOP = 4'b1000
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] pos, pos_next;
  logic [7:0] left, left_next;
  logic [7:0] stype, stype_next;
  logic       pair, pair_next;
  logic [7:0] low, low_next;
  logic       match, match_next;
  logic       done, done_next;
  logic [7:0] count, count_next;

  logic [8:0] struct_end;
  logic [7:0] left_dec;
  logic       is_uuid, is_name, byte_name;

  assign struct_end = {1'b0, pos} + 9'd1 + {1'b0, adv_byte};
  assign left_dec   = left - 8'd1;
  assign is_uuid    = (stype == bas_pkg::AdUuid16Part) || (stype == bas_pkg::AdUuid16Full);
  assign is_name    = (stype == bas_pkg::AdNameShort) || (stype == bas_pkg::AdNameFull);
  assign byte_name  = (adv_byte == bas_pkg::AdNameShort) ||
                      (adv_byte == bas_pkg::AdNameFull);

  always_comb begin
    phase_next = phase;
    pos_next   = pos;
    left_next  = left;
    stype_next = stype;
    pair_next  = pair;
    low_next   = low;
    match_next = match;
    done_next  = done;
    count_next = count;
    res        = '0;
    if (fire) begin
      if (pos < adv_len) begin
        case (phase)
          PH_LEN: begin
            if (adv_byte == 8'd0 || struct_end > {1'b0, adv_len}) begin
              phase_next = PH_STOP;
            end else begin
              left_next  = adv_byte;
              phase_next = PH_TYPE;
            end
          end
          PH_TYPE: begin
            stype_next = adv_byte;
            pair_next  = 1'b0;
            left_next  = left_dec;
            if (left_dec == 8'd0) begin
              if (byte_name) done_next = 1'b1;
              phase_next = PH_LEN;
            end else begin
              phase_next = PH_PAY;
            end
          end
          PH_PAY: begin
            if (is_uuid) begin
              if (!pair) begin
                low_next  = adv_byte;
                pair_next = 1'b1;
              end else begin
                if ({adv_byte, low} == uuid_cfg) match_next = 1'b1;
                pair_next = 1'b0;
              end
            end else if (is_name && !done && count < bas_pkg::NameLimit) begin
              res.name_vld  = 1'b1;
              res.name_byte = adv_byte;
              count_next    = count + 8'd1;
            end
            left_next = left_dec;
            if (left_dec == 8'd0) begin
              if (is_name) done_next = 1'b1;
              phase_next = PH_LEN;
            end
          end
          default: begin
          end
        endcase
      end
      if (pos != 8'hFF) pos_next = pos + 8'd1;
      if (last) begin
        res.sum_vld  = 1'b1;
        res.found    = match_next;
        res.name_len = count_next;
        phase_next   = PH_LEN;
        pos_next     = '0;
        left_next    = '0;
        stype_next   = '0;
        pair_next    = 1'b0;
        low_next     = '0;
        match_next   = 1'b0;
        done_next    = 1'b0;
        count_next   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LEN;
      pos   <= '0;
      left  <= '0;
      stype <= '0;
      pair  <= 1'b0;
      low   <= '0;
      match <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      phase <= phase_next;
      pos   <= pos_next;
      left  <= left_next;
      stype <= stype_next;
      pair  <= pair_next;
      low   <= low_next;
      match <= match_next;
      done  <= done_next;
      count <= count_next;
    end
  end

endmodule

### rtl/bas_res_fifo.sv
// Result queue: takes up to two results a cycle, hands out one per request.
module bas_res_fifo (
  input  logic               clk,
  input  logic               rst,
  input  bas_pkg::res_pair_t res,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               kind,
  output logic [7:0]         name_byte,
  output logic               uuid_found,
  output logic [7:0]         name_length,
  output logic               result_last
);

  bas_pkg::result_t entry [bas_pkg::FifoDepth];
  bas_pkg::result_t name_res, sum_res, head;

  logic [bas_pkg::FifoAw-1:0] wr, rd, wr_next, rd_next, wr_sum;
  logic [bas_pkg::FifoCw-1:0] count, count_next;
  logic                       pop;

  assign name_res = '{kind: bas_pkg::KindName, name_byte: res.name_byte,
                      uuid_found: 1'b0, name_length: 8'd0, result_last: 1'b0};
  assign sum_res  = '{kind: bas_pkg::KindSummary, name_byte: 8'd0,
                      uuid_found: res.found, name_length: res.name_len,
                      result_last: 1'b1};

  // Leave space for the worst case of two results from the next request.
  assign room      = count <= bas_pkg::FifoCw'(bas_pkg::FifoDepth - 2);
  assign out_valid = count != '0;
  assign pop       = out_valid && out_ready;
  assign wr_sum    = res.name_vld ? wr + bas_pkg::FifoAw'(1) : wr;

  always_comb begin
    wr_next    = wr + bas_pkg::FifoAw'(res.name_vld) + bas_pkg::FifoAw'(res.sum_vld);
    rd_next    = rd + bas_pkg::FifoAw'(pop);
    count_next = count + bas_pkg::FifoCw'(res.name_vld) + bas_pkg::FifoCw'(res.sum_vld)
                 - bas_pkg::FifoCw'(pop);
  end

  always_ff @(posedge clk) begin
    if (res.name_vld) entry[wr] <= name_res;
    if (res.sum_vld) entry[wr_sum] <= sum_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      wr    <= wr_next;
      rd    <= rd_next;
      count <= count_next;
    end
  end

  assign head        = entry[rd];
  assign kind        = head.kind;
  assign name_byte   = head.name_byte;
  assign uuid_found  = head.uuid_found;
  assign name_length = head.name_length;
  assign result_last = head.result_last;

endmodule

### rtl/ble_adv_service_and_name_scanner.sv
// Top level of the advertising payload scanner: service UUID match and local name.
//
//   channel  direction  handshake              payload
//   in       to block   in_valid / in_ready    adv_byte, adv_len, last
//   out      from block out_valid / out_ready  kind, name_byte, uuid_found,
//                                              name_length, result_last
//   cfg      to block   cfg_valid / cfg_ready  match_uuid
//
// One byte request is taken per cycle; its results are written into a
// four-entry queue at the accepting edge and show on the output from the next
// cycle. A byte causes at most two results (a name byte, then the summary on
// the last byte). in_ready drops while the queue could not absorb two more
// results, so a stalled output side holds the input once three results wait.
// Synchronous reset clears parse state and the queue, and loads the UUID
// register with 0x1826; cfg_ready is always high.
module ble_adv_service_and_name_scanner (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  adv_byte,
  input  logic [7:0]  adv_len,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [7:0]  name_byte,
  output logic        uuid_found,
  output logic [7:0]  name_length,
  output logic        result_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] match_uuid
);

  logic               fire;
  logic               room;
  logic [15:0]        uuid_cfg;
  bas_pkg::res_pair_t res;

  // Take a config write in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      uuid_cfg <= bas_pkg::MatchUuidRst;
    end else if (cfg_valid) begin
      uuid_cfg <= match_uuid;
    end
  end

  // Advance the parser only on an accepted byte request.
  assign in_ready = room;
  assign fire     = in_valid && room;

  bas_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .adv_byte (adv_byte),
    .adv_len  (adv_len),
    .last     (last),
    .uuid_cfg (uuid_cfg),
    .res      (res)
  );

  // Hold results until the consumer takes them.
  bas_res_fifo u_fifo (
    .clk         (clk),
    .rst         (rst),
    .res         (res),
    .room        (room),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .name_byte   (name_byte),
    .uuid_found  (uuid_found),
    .name_length (name_length),
    .result_last (result_last)
  );

endmodule
